/* design/psm_pkg.sv */
`default_nettype none
package psm_pkg;

  localparam int WordW  = 32;
  localparam int AddrW  = 9;    // stack index, 512 entries
  localparam int PcW    = 11;   // program span 2048
  localparam int OperW  = 11;
  localparam int Depth  = 1 << AddrW;

  typedef enum logic [2:0] {
    MODE_LIT = 3'd0, MODE_OPR = 3'd1, MODE_LOD = 3'd2, MODE_STO = 3'd3,
    MODE_CAL = 3'd4, MODE_INT = 3'd5, MODE_JMP = 3'd6, MODE_JPC = 3'd7
  } mode_e;

  // opr sub-operations
  localparam logic [OperW-1:0] OPR_RET = 11'd0;
  localparam logic [OperW-1:0] OPR_NEG = 11'd1;
  localparam logic [OperW-1:0] OPR_ADD = 11'd2;
  localparam logic [OperW-1:0] OPR_SUB = 11'd3;
  localparam logic [OperW-1:0] OPR_MUL = 11'd4;
  localparam logic [OperW-1:0] OPR_DIV = 11'd5;
  localparam logic [OperW-1:0] OPR_ODD = 11'd6;
  localparam logic [OperW-1:0] OPR_EQ  = 11'd8;
  localparam logic [OperW-1:0] OPR_NE  = 11'd9;
  localparam logic [OperW-1:0] OPR_LT  = 11'd10;
  localparam logic [OperW-1:0] OPR_GE  = 11'd11;
  localparam logic [OperW-1:0] OPR_GT  = 11'd12;
  localparam logic [OperW-1:0] OPR_LE  = 11'd13;

  typedef enum logic [1:0] {
    FLT_NONE = 2'd0, FLT_OVER = 2'd1, FLT_UNDER = 2'd2, FLT_DIVZ = 2'd3
  } fault_e;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_EXEC, ST_CAL2, ST_CAL3, ST_DIV, ST_TOP, ST_LOAD
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic clr;       // write zero at clear pointer
    logic latch;     // capture the incoming instruction
    logic rd_ops;    // read operands
    logic exec;      // evaluate and commit
    logic cal2;      // second link slot
    logic cal3;      // return slot and jump
    logic div_fin;   // write quotient
    logic rd_top;    // read word at top
    logic load_out;  // fill output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic halted;
    logic go_cal;
    logic go_div;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

/* design/pcode_stack_machine_step.sv */
// Steps: each accepted instruction passes through read, execute, top read and output load;
// cal adds two states that write the second link slot and the return slot, divide waits in
// a divide state (one quotient bit a cycle), and once halted only top read and load run.
// Throughput: one instruction at a time; the next transfer is taken the cycle after the
// result is loaded, longer while the result waits.
// Reset: asynchronous, active low; a clearing pass then zeroes the stack, no input transfer is taken until it ends.
`default_nettype none
module pcode_stack_machine_step import psm_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // mode[2:0], operand_address[13:3], zero pad
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata   // next_pc[10:0], frame_base[19:11],
                                          // top_index[28:20], top_value[60:29],
                                          // halted[61], fault[63:62]
);

  cmd_t   cmd;
  sts_t   sts;
  state_e state;

  psm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .state_o    (state)
  );

  psm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .mode_i      (s_axis_tdata[2:0]),
    .oper_i      (s_axis_tdata[13:3]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

  // halt is sticky until reset
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(sts.halted)) else $error("halt flag cleared");

  // no input transfer while the stack is being cleared
  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state == ST_CLEAR) |-> !s_axis_tready) else $error("accept during clear");

  // a result produced while already halted never carries a fault
  a_halt_no_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[61] && $past(sts.halted) && $past(m_axis_tvalid) == 1'b0)
    |-> (m_axis_tdata[63:62] == FLT_NONE || !$past(sts.halted, 8)))
    else $error("fault reported while halted");

endmodule
`default_nettype wire

/* design/psm_div.sv */
`default_nettype none
module psm_div import psm_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [WordW-1:0] dividend_i,
  input  wire logic [WordW-1:0] divisor_i,
  output logic                  done_o,
  output logic [WordW-1:0]      quot_o
);

  localparam int CntW = $clog2(WordW);

  logic [WordW-1:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d, neg_q, neg_d;
  logic [WordW:0]   trial;
  logic [WordW:0]   shifted;

  // one quotient bit per cycle, restoring, on magnitudes
  always_comb begin
    rem_d   = rem_q;
    quo_d   = quo_q;
    den_d   = den_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    neg_d   = neg_q;
    done_d  = 1'b0;
    shifted = {rem_q, quo_q[WordW-1]};
    trial   = shifted - {1'b0, den_q};
    if (start_i) begin
      quo_d  = dividend_i[WordW-1] ? (-dividend_i) : dividend_i;
      den_d  = divisor_i[WordW-1] ? (-divisor_i) : divisor_i;
      neg_d  = dividend_i[WordW-1] ^ divisor_i[WordW-1];
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[WordW]) begin
        rem_d = trial[WordW-1:0];
      end else begin
        rem_d = shifted[WordW-1:0];
      end
      quo_d = {quo_q[WordW-2:0], ~trial[WordW]};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(WordW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    cnt_q <= cnt_d;
    neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? (-quo_q) : quo_q;

endmodule
`default_nettype wire

/* design/psm_ctrl.sv */
`default_nettype none
module psm_ctrl import psm_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o,
  output state_e    state_o
);

  state_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (sts_i.clr_last) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_valid_i) state_d = sts_i.halted ? ST_TOP : ST_READ;
      end
      ST_READ: state_d = ST_EXEC;
      ST_EXEC: begin
        if (sts_i.go_cal) state_d = ST_CAL2;
        else if (sts_i.go_div) state_d = ST_DIV;
        else state_d = ST_TOP;
      end
      ST_CAL2: state_d = ST_CAL3;
      ST_CAL3: state_d = ST_TOP;
      ST_DIV:  if (sts_i.div_done) state_d = ST_TOP;
      ST_TOP:  state_d = ST_LOAD;
      ST_LOAD: if (sts_i.out_free) state_d = ST_IDLE;
      default: state_d = ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: cmd_o.clr = 1'b1;
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.latch = in_valid_i;
      end
      ST_READ: cmd_o.rd_ops = 1'b1;
      ST_EXEC: cmd_o.exec = 1'b1;
      ST_CAL2: cmd_o.cal2 = 1'b1;
      ST_CAL3: cmd_o.cal3 = 1'b1;
      ST_DIV:  cmd_o.div_fin = sts_i.div_done;
      ST_TOP:  cmd_o.rd_top = 1'b1;
      ST_LOAD: cmd_o.load_out = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign state_o = state_q;

endmodule
`default_nettype wire

/* design/psm_dp.sv */
`default_nettype none
module psm_dp import psm_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cmd_t             cmd_i,
  output sts_t                  sts_o,
  input  wire logic [2:0]       mode_i,
  input  wire logic [OperW-1:0] oper_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [63:0]           out_data_o
);

  // architectural state
  logic [PcW-1:0]   pc_q;
  logic [AddrW-1:0] b_q, t_q;
  logic             halt_q;
  // instruction and step state
  mode_e            mode_q;
  logic [OperW-1:0] a_q;
  logic [1:0]       fault_q;
  logic [AddrW-1:0] clr_q;
  // stack memory with two registered read ports
  logic [WordW-1:0] mem [Depth];
  logic [WordW-1:0] rd0_q, rd1_q;
  logic [AddrW-1:0] ra0, ra1;
  logic             we;
  logic [AddrW-1:0] wa;
  logic [WordW-1:0] wd;
  // output register
  logic             ov_q;
  logic [63:0]      od_q;

  // step evaluation
  logic [AddrW:0]     t_ext, b_ext;
  logic [OperW+1:0]   addr_ba;
  logic [PcW-1:0]     np;
  logic [AddrW-1:0]   nb, nt;
  logic [1:0]         flt;
  logic               ex_we, go_cal, go_div, is_bin;
  logic [AddrW-1:0]   ex_wa;
  logic [WordW-1:0]   ex_wd, bin_res, prod;
  logic               div_done;
  logic [WordW-1:0]   quot;

  assign t_ext   = {1'b0, t_q};
  assign b_ext   = {1'b0, b_q};
  assign addr_ba = {4'b0, b_q} + {2'b0, a_q};
  assign prod    = rd0_q * rd1_q;
  assign is_bin  = (a_q >= OPR_ADD && a_q <= OPR_DIV) || (a_q >= OPR_EQ && a_q <= OPR_LE);

  // binary opr result, rd0 is second from top, rd1 is top
  always_comb begin
    case (a_q)
      OPR_ADD: bin_res = rd0_q + rd1_q;
      OPR_SUB: bin_res = rd0_q - rd1_q;
      OPR_MUL: bin_res = prod;
      OPR_EQ:  bin_res = WordW'(rd0_q == rd1_q);
      OPR_NE:  bin_res = WordW'(rd0_q != rd1_q);
      OPR_LT:  bin_res = WordW'($signed(rd0_q) < $signed(rd1_q));
      OPR_GE:  bin_res = WordW'($signed(rd0_q) >= $signed(rd1_q));
      OPR_GT:  bin_res = WordW'($signed(rd0_q) > $signed(rd1_q));
      default: bin_res = WordW'($signed(rd0_q) <= $signed(rd1_q));
    endcase
  end

  // instruction effect, operands already read
  always_comb begin
    np     = pc_q + 1'b1;
    nb     = b_q;
    nt     = t_q;
    flt    = FLT_NONE;
    ex_we  = 1'b0;
    ex_wa  = t_q;
    ex_wd  = rd1_q;
    go_cal = 1'b0;
    go_div = 1'b0;
    case (mode_q)
      MODE_LIT: begin
        if (t_ext + 1'b1 >= (AddrW+1)'(Depth)) flt = FLT_OVER;
        else begin
          nt = t_q + 1'b1; ex_we = 1'b1; ex_wa = nt; ex_wd = WordW'(a_q);
        end
      end
      MODE_OPR: begin
        if (a_q == OPR_RET) begin
          if (b_ext + 2'd2 >= (AddrW+1)'(Depth)) flt = FLT_OVER;
          else begin
            np = rd1_q[PcW-1:0];
            nb = rd0_q[AddrW-1:0];
            nt = (b_q != '0) ? b_q - 1'b1 : '0;
          end
        end else if (a_q == OPR_NEG) begin
          ex_we = 1'b1; ex_wd = -rd1_q;
        end else if (a_q == OPR_ODD) begin
          ex_we = 1'b1; ex_wd = {{(WordW-1){1'b0}}, rd1_q[0]};
        end else if (is_bin) begin
          if (t_q == '0) flt = FLT_UNDER;
          else if (a_q == OPR_DIV && rd1_q == '0) flt = FLT_DIVZ;
          else if (a_q == OPR_DIV) go_div = 1'b1;
          else begin
            nt = t_q - 1'b1; ex_we = 1'b1; ex_wa = nt; ex_wd = bin_res;
          end
        end
      end
      MODE_LOD: begin
        if (t_ext + 1'b1 >= (AddrW+1)'(Depth) || addr_ba >= (OperW+2)'(Depth)) flt = FLT_OVER;
        else begin
          nt = t_q + 1'b1; ex_we = 1'b1; ex_wa = nt; ex_wd = rd0_q;
        end
      end
      MODE_STO: begin
        if (addr_ba >= (OperW+2)'(Depth)) flt = FLT_OVER;
        else if (t_q == '0) flt = FLT_UNDER;
        else begin
          nt = t_q - 1'b1; ex_we = 1'b1; ex_wa = addr_ba[AddrW-1:0]; ex_wd = rd1_q;
        end
      end
      MODE_CAL: begin
        if (t_ext + 2'd3 >= (AddrW+1)'(Depth)) flt = FLT_OVER;
        else begin
          go_cal = 1'b1; ex_we = 1'b1; ex_wa = t_q + 1'b1; ex_wd = WordW'(b_q);
        end
      end
      MODE_INT: begin
        if ({4'b0, t_q} + {2'b0, a_q} >= (OperW+2)'(Depth)) flt = FLT_OVER;
        else nt = t_q + a_q[AddrW-1:0];
      end
      MODE_JMP: np = a_q[PcW-1:0];
      default: begin
        if (t_q == '0) flt = FLT_UNDER;
        else begin
          if (rd1_q == '0) np = a_q[PcW-1:0];
          nt = t_q - 1'b1;
        end
      end
    endcase
    if (flt != FLT_NONE) begin
      np = pc_q; nb = b_q; nt = t_q;
    end
  end

  // read addresses: port 0 second operand, load address or link, port 1 top or return slot
  always_comb begin
    ra0 = t_q - 1'b1;
    ra1 = t_q;
    if (cmd_i.rd_ops) begin
      if (mode_q == MODE_LOD) ra0 = addr_ba[AddrW-1:0];
      else if (mode_q == MODE_OPR && a_q == OPR_RET) begin
        ra0 = b_q + 1'b1;
        ra1 = b_q + 2'd2;
      end
    end else if (cmd_i.rd_top) begin
      ra1 = t_q;
    end
  end

  // write port
  always_comb begin
    we = 1'b0; wa = ex_wa; wd = ex_wd;
    if (cmd_i.clr) begin
      we = 1'b1; wa = clr_q; wd = '0;
    end else if (cmd_i.exec) begin
      we = ex_we;
    end else if (cmd_i.cal2) begin
      we = 1'b1; wa = t_q + 2'd2; wd = WordW'(b_q);
    end else if (cmd_i.cal3) begin
      // return address wraps within the program span
      we = 1'b1; wa = t_q + 2'd3; wd = WordW'(PcW'(pc_q + 1'b1));
    end else if (cmd_i.div_fin) begin
      we = 1'b1; wa = t_q - 1'b1; wd = quot;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    rd0_q <= mem[ra0];
    rd1_q <= mem[ra1];
  end

  psm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.exec & go_div),
    .dividend_i (rd0_q),
    .divisor_i  (rd1_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // architectural registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= '0;
      b_q    <= '0;
      t_q    <= '0;
      halt_q <= 1'b0;
      clr_q  <= '0;
      ov_q   <= 1'b0;
    end else begin
      if (cmd_i.clr) clr_q <= clr_q + 1'b1;
      if (cmd_i.exec && !go_cal && !go_div) begin
        pc_q   <= np;
        b_q    <= nb;
        t_q    <= nt;
        halt_q <= (np == '0);
      end
      if (cmd_i.cal3) begin
        pc_q   <= a_q[PcW-1:0];
        b_q    <= t_q + 1'b1;
        halt_q <= (a_q[PcW-1:0] == '0);
      end
      if (cmd_i.div_fin) begin
        pc_q   <= pc_q + 1'b1;
        t_q    <= t_q - 1'b1;
        halt_q <= (pc_q + 1'b1 == '0);
      end
      if (cmd_i.load_out) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  // instruction capture, fault and output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      mode_q  <= mode_e'(mode_i);
      a_q     <= oper_i;
      fault_q <= FLT_NONE;
    end
    if (cmd_i.exec) fault_q <= flt;
    if (cmd_i.load_out) od_q <= {fault_q, halt_q, rd1_q, t_q, b_q, pc_q};
  end

  assign sts_o.clr_last = (clr_q == '1);
  assign sts_o.halted   = halt_q;
  assign sts_o.go_cal   = go_cal;
  assign sts_o.go_div   = go_div;
  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !ov_q || out_ready_i;
  assign out_valid_o    = ov_q;
  assign out_data_o     = od_q;

endmodule
`default_nettype wire
